// ===== rtl/sgns_pkg.sv =====
// Shared constants and helpers for the skip-gram negative-sampling trainer.
`timescale 1ns / 1ps
`default_nettype none
package sgns_pkg;

  localparam int VOCAB_W     = 12;
  localparam int DIM         = 128;
  localparam int DIM_W       = 7;
  localparam int UNI_W       = 16;
  localparam int SIG_ENTRIES = 1000;
  localparam int SIG_AW      = 10;
  localparam int SIG_HALF    = 500;

  localparam logic [2:0] CMD_TABLE_WR = 3'd0;
  localparam logic [2:0] CMD_IN_WR    = 3'd1;
  localparam logic [2:0] CMD_OUT_WR   = 3'd2;
  localparam logic [2:0] CMD_TRAIN    = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;

  localparam logic [2:0] CFG_DIM     = 3'd0;
  localparam logic [2:0] CFG_NEG     = 3'd1;
  localparam logic [2:0] CFG_RATE    = 3'd2;
  localparam logic [2:0] CFG_VOCAB   = 3'd3;
  localparam logic [2:0] CFG_SEED    = 3'd4;

  localparam logic [7:0]  DIM_RESET   = 8'd100;
  localparam logic [3:0]  NEG_RESET   = 4'd5;
  localparam logic [24:0] RATE_RESET  = 25'd419430;
  localparam logic [12:0] VOCAB_RESET = 13'd4096;
  localparam logic [63:0] SEED_RESET  = 64'd123456;

  localparam logic [34:0] LCG_MUL  = 35'd25214903917;
  localparam logic [63:0] LCG_ADD  = 64'd11;
  localparam logic [31:0] EXP_STEP = 32'd4243735693;
  localparam logic [24:0] ONE_Q24  = 25'd16777216;
  localparam logic signed [47:0] LIMIT_Q24 = 48'sd100663296;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/skipgram_negative_sampling_update_top.sv =====
// Top level of the skip-gram negative-sampling trainer with its memories and sequencer.
`timescale 1ns / 1ps
`default_nettype none
// After reset the block builds its sigmoid table before the first request is taken;
// configuration writes are accepted throughout. Table and vector writes, reads and unknown
// commands pass through the execute and finish states only. A training request, for each scored
// target, runs the dot product (read, multiply and accumulate steps per element) and then the
// updates (read, two multiply and write steps per element), all through one shared multiplier;
// each negative drawn steps the random generator with a bit-serial multiplier, a drawn entry that
// is zero is remapped by the serial divider, and a final pass updates the input vector. A new
// request is taken once the previous one has finished, even while its result still waits at the
// output.
module skipgram_negative_sampling_update_top (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [2:0]         in_command,
  input  wire  [11:0]        in_node,
  input  wire  [11:0]        in_context_node,
  input  wire  [15:0]        in_position,
  input  wire  signed [31:0] in_element_value,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] out_read_value,
  output logic [2:0]         out_done_kind,
  input  wire                cfg_we,
  input  wire  [2:0]         cfg_index,
  input  wire  [63:0]        cfg_data
);

  localparam logic [4:0] S_ISETUP  = 5'd0;
  localparam logic [4:0] S_IDIV    = 5'd1;
  localparam logic [4:0] S_IWR1    = 5'd2;
  localparam logic [4:0] S_IWR2    = 5'd3;
  localparam logic [4:0] S_IEXP    = 5'd4;
  localparam logic [4:0] S_IUPD    = 5'd5;
  localparam logic [4:0] S_IDLE    = 5'd6;
  localparam logic [4:0] S_EXEC    = 5'd7;
  localparam logic [4:0] S_FIN     = 5'd8;
  localparam logic [4:0] T_DRD     = 5'd9;
  localparam logic [4:0] T_DMUL    = 5'd10;
  localparam logic [4:0] T_DACC    = 5'd11;
  localparam logic [4:0] T_SIG0    = 5'd12;
  localparam logic [4:0] T_SIG1    = 5'd13;
  localparam logic [4:0] T_GRAD    = 5'd14;
  localparam logic [4:0] T_URD     = 5'd15;
  localparam logic [4:0] T_UM1     = 5'd16;
  localparam logic [4:0] T_UM2     = 5'd17;
  localparam logic [4:0] T_UW      = 5'd18;
  localparam logic [4:0] T_NEXT    = 5'd19;
  localparam logic [4:0] T_LCG     = 5'd20;
  localparam logic [4:0] T_LSTORE  = 5'd21;
  localparam logic [4:0] T_UNI     = 5'd22;
  localparam logic [4:0] T_UCHK    = 5'd23;
  localparam logic [4:0] T_MOD     = 5'd24;
  localparam logic [4:0] T_MODDONE = 5'd25;
  localparam logic [4:0] T_FRD     = 5'd26;
  localparam logic [4:0] T_FW      = 5'd27;

  localparam int VEC_AW = sgns_pkg::VOCAB_W + sgns_pkg::DIM_W;

  logic [4:0]  state_r;
  logic [7:0]  dim_cfg_r;
  logic [3:0]  neg_cfg_r;
  logic [24:0] rate_r;
  logic [12:0] vocab_r;
  logic [63:0] rand_r;

  logic [2:0]         cmd_r;
  logic [11:0]        node_r;
  logic [11:0]        ctx_r;
  logic [15:0]        pos_r;
  logic signed [31:0] val_r;

  logic [11:0]        tgt_r;
  logic               lab_one_r;
  logic               first_r;
  logic [3:0]         drawn_r;
  logic [7:0]         cnt_r;
  logic signed [47:0] f_r;
  logic signed [26:0] g_r;
  logic signed [65:0] prod_r;
  logic [1:0]         sig_sel_r;

  logic [65:0] ma_r;
  logic [34:0] mb_r;
  logic [65:0] mp_r;
  logic [5:0]  mcnt_r;

  logic [63:0] dn_r;
  logic [33:0] dd_r;
  logic [33:0] dr_r;
  logic [24:0] dq_r;
  logic [6:0]  dcnt_r;

  logic [8:0]  m_r;
  logic [32:0] e_r;

  logic               out_valid_r;
  logic signed [31:0] out_read_value_r;
  logic [2:0]         out_done_kind_r;

  logic signed [31:0] in_mem_r [0:(1 << VEC_AW) - 1];
  logic signed [31:0] out_mem_r [0:(1 << VEC_AW) - 1];
  logic signed [31:0] err_mem_r [0:sgns_pkg::DIM - 1];
  logic [11:0]        uni_mem_r [0:(1 << sgns_pkg::UNI_W) - 1];
  logic [24:0]        sig_mem_r [0:sgns_pkg::SIG_ENTRIES - 1];

  logic signed [31:0] in_q_r;
  logic signed [31:0] out_q_r;
  logic signed [31:0] err_q_r;
  logic [11:0]        uni_q_r;
  logic [24:0]        sig_q_r;

  logic [VEC_AW-1:0]         in_addr;
  logic                      in_we;
  logic                      in_re;
  logic signed [31:0]        in_wd;
  logic [VEC_AW-1:0]         out_addr;
  logic                      out_we;
  logic                      out_re;
  logic signed [31:0]        out_wd;
  logic [sgns_pkg::DIM_W-1:0] err_addr;
  logic                      err_we;
  logic                      err_re;
  logic signed [31:0]        err_wd;
  logic [sgns_pkg::UNI_W-1:0] uni_addr;
  logic                      uni_we;
  logic                      uni_re;
  logic [sgns_pkg::SIG_AW-1:0] sig_addr;
  logic                      sig_we;
  logic                      sig_re;
  logic [24:0]               sig_wd;

  logic [7:0]         dim_eff;
  logic [11:0]        veff_m1;
  logic               pos_ok;
  logic signed [41:0] prod_fl;
  logic signed [47:0] prod_fl48;
  logic signed [47:0] err_base;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [25:0] diff;
  logic [24:0]        s_val;
  logic [28:0]        sig_x;
  logic [35:0]        sig_x83;
  logic [10:0]        sig_idx11;
  logic [9:0]         sig_idx;
  logic [65:0]        mp_step;
  logic [34:0]        div_t;
  logic               div_ge;
  logic [33:0]        dr_step;
  logic [33:0]        den;
  logic [56:0]        num;
  logic [7:0]         cnt_inc;
  logic [11:0]        mod_cand;

  assign dim_eff = (dim_cfg_r > 8'(sgns_pkg::DIM)) ? 8'(sgns_pkg::DIM) : dim_cfg_r;
  assign veff_m1 = (vocab_r < 13'd2) ? 12'd1 :
                   (vocab_r > 13'd4096) ? 12'd4095 : 12'(vocab_r - 13'd1);
  assign pos_ok    = (pos_r[15:sgns_pkg::DIM_W] == '0);
  assign prod_fl   = prod_r[65:24];
  assign prod_fl48 = 48'(prod_fl);
  assign err_base  = first_r ? 48'sd0 : 48'(err_q_r);
  assign cnt_inc   = cnt_r + 8'd1;
  assign mod_cand  = dr_r[11:0] + 12'd1;

  assign s_val = (sig_sel_r == 2'd1) ? sgns_pkg::ONE_Q24 :
                 (sig_sel_r == 2'd2) ? 25'd0 : sig_q_r;
  assign diff  = $signed({1'b0, (lab_one_r ? sgns_pkg::ONE_Q24 : 25'd0)}) -
                 $signed({1'b0, s_val});

  assign sig_x     = 29'(f_r + sgns_pkg::LIMIT_Q24);
  assign sig_x83   = ({7'd0, sig_x} << 6) + ({7'd0, sig_x} << 4) + ({7'd0, sig_x} << 1) +
                     {7'd0, sig_x};
  assign sig_idx11 = sig_x83[34:24];
  assign sig_idx   = (sig_idx11 >= 11'(sgns_pkg::SIG_ENTRIES)) ?
                     10'(sgns_pkg::SIG_ENTRIES - 1) : sig_idx11[9:0];

  assign mp_step = mp_r + (mb_r[0] ? ma_r : 66'd0);

  assign div_t   = {dr_r, dn_r[63]};
  assign div_ge  = (div_t >= {1'b0, dd_r});
  assign dr_step = div_ge ? 34'(div_t - {1'b0, dd_r}) : div_t[33:0];

  assign den = {1'b0, e_r} + 34'h1_0000_0000;
  assign num = (57'd1 << 56) + {24'd0, den[33:1]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      T_DMUL: begin
        mul_a = 33'(in_q_r);
        mul_b = 33'(out_q_r);
      end
      T_SIG1: begin
        mul_a = 33'(diff);
        mul_b = {8'd0, rate_r};
      end
      T_UM1: begin
        mul_a = 33'(g_r);
        mul_b = 33'(out_q_r);
      end
      T_UM2: begin
        mul_a = 33'(g_r);
        mul_b = 33'(in_q_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    in_addr  = {ctx_r, cnt_r[sgns_pkg::DIM_W-1:0]};
    out_addr = {tgt_r, cnt_r[sgns_pkg::DIM_W-1:0]};
    err_addr = cnt_r[sgns_pkg::DIM_W-1:0];
    uni_addr = rand_r[31:16];
    sig_addr = sig_idx;
    in_we  = 1'b0;
    in_re  = 1'b0;
    in_wd  = sgns_pkg::sat32(48'(in_q_r) + 48'(err_q_r));
    out_we = 1'b0;
    out_re = 1'b0;
    out_wd = sgns_pkg::sat32(48'(out_q_r) + prod_fl48);
    err_we = 1'b0;
    err_re = 1'b0;
    err_wd = sgns_pkg::sat32(err_base + prod_fl48);
    uni_we = 1'b0;
    uni_re = 1'b0;
    sig_we = 1'b0;
    sig_re = 1'b0;
    sig_wd = dq_r;
    case (state_r)
      S_IWR1: begin
        sig_addr = 10'(sgns_pkg::SIG_HALF) + {1'b0, m_r};
        sig_we   = (m_r < 9'(sgns_pkg::SIG_HALF));
      end
      S_IWR2: begin
        sig_addr = 10'(sgns_pkg::SIG_HALF) - {1'b0, m_r};
        sig_we   = (m_r != 9'd0);
        sig_wd   = sgns_pkg::ONE_Q24 - dq_r;
      end
      S_EXEC: begin
        in_addr  = {node_r, pos_r[sgns_pkg::DIM_W-1:0]};
        out_addr = {node_r, pos_r[sgns_pkg::DIM_W-1:0]};
        uni_addr = pos_r;
        in_wd    = val_r;
        out_wd   = val_r;
        in_we    = (cmd_r == sgns_pkg::CMD_IN_WR) && pos_ok;
        out_we   = (cmd_r == sgns_pkg::CMD_OUT_WR) && pos_ok;
        uni_we   = (cmd_r == sgns_pkg::CMD_TABLE_WR);
        in_re    = (cmd_r == sgns_pkg::CMD_READ);
      end
      T_DRD, T_URD: begin
        in_re  = 1'b1;
        out_re = 1'b1;
        err_re = (state_r == T_URD);
      end
      T_SIG0: sig_re = 1'b1;
      T_UM2:  err_we = 1'b1;
      T_UW:   out_we = 1'b1;
      T_UNI:  uni_re = 1'b1;
      T_FRD: begin
        in_re  = 1'b1;
        err_re = 1'b1;
      end
      T_FW: in_we = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_we) begin
      in_mem_r[in_addr] <= in_wd;
    end
    if (in_re) begin
      in_q_r <= in_mem_r[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (out_we) begin
      out_mem_r[out_addr] <= out_wd;
    end
    if (out_re) begin
      out_q_r <= out_mem_r[out_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (err_we) begin
      err_mem_r[err_addr] <= err_wd;
    end
    if (err_re) begin
      err_q_r <= err_mem_r[err_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (uni_we) begin
      uni_mem_r[uni_addr] <= node_r;
    end
    if (uni_re) begin
      uni_q_r <= uni_mem_r[uni_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (sig_we) begin
      sig_mem_r[sig_addr] <= sig_wd;
    end
    if (sig_re) begin
      sig_q_r <= sig_mem_r[sig_addr];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ISETUP;
      dim_cfg_r   <= sgns_pkg::DIM_RESET;
      neg_cfg_r   <= sgns_pkg::NEG_RESET;
      rate_r      <= sgns_pkg::RATE_RESET;
      vocab_r     <= sgns_pkg::VOCAB_RESET;
      rand_r      <= sgns_pkg::SEED_RESET;
      m_r         <= '0;
      e_r         <= 33'h1_0000_0000;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_ISETUP: begin
          dn_r   <= {7'd0, num};
          dd_r   <= den;
          dr_r   <= '0;
          dq_r   <= '0;
          dcnt_r <= 7'd64;
          state_r <= S_IDIV;
        end
        S_IDIV: begin
          dr_r   <= dr_step;
          dq_r   <= {dq_r[23:0], div_ge};
          dn_r   <= {dn_r[62:0], 1'b0};
          dcnt_r <= dcnt_r - 7'd1;
          if (dcnt_r == 7'd1) begin
            state_r <= S_IWR1;
          end
        end
        S_IWR1: state_r <= S_IWR2;
        S_IWR2: begin
          ma_r    <= {34'd0, sgns_pkg::EXP_STEP};
          mb_r    <= {2'd0, e_r};
          mp_r    <= '0;
          mcnt_r  <= 6'd35;
          state_r <= S_IEXP;
        end
        S_IEXP: begin
          mp_r   <= mp_step;
          ma_r   <= {ma_r[64:0], 1'b0};
          mb_r   <= {1'b0, mb_r[34:1]};
          mcnt_r <= mcnt_r - 6'd1;
          if (mcnt_r == 6'd1) begin
            state_r <= S_IUPD;
          end
        end
        S_IUPD: begin
          e_r <= 33'((mp_r + 66'h8000_0000) >> 32);
          m_r <= m_r + 9'd1;
          state_r <= (m_r == 9'(sgns_pkg::SIG_HALF)) ? S_IDLE : S_ISETUP;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_command;
            node_r  <= in_node;
            ctx_r   <= in_context_node;
            pos_r   <= in_position;
            val_r   <= in_element_value;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          tgt_r     <= node_r;
          lab_one_r <= 1'b1;
          first_r   <= 1'b1;
          drawn_r   <= '0;
          f_r       <= '0;
          cnt_r     <= '0;
          if (cmd_r != sgns_pkg::CMD_TRAIN || neg_cfg_r == 4'd0) begin
            state_r <= S_FIN;
          end else begin
            state_r <= (dim_eff == 8'd0) ? T_SIG0 : T_DRD;
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r      <= 1'b1;
            out_read_value_r <= (cmd_r == sgns_pkg::CMD_READ && pos_ok) ? in_q_r : 32'sd0;
            out_done_kind_r  <= cmd_r;
            state_r          <= S_IDLE;
          end
        end
        T_DRD:  state_r <= T_DMUL;
        T_DMUL: state_r <= T_DACC;
        T_DACC: begin
          f_r   <= f_r + prod_fl48;
          cnt_r <= cnt_inc;
          state_r <= (cnt_inc == dim_eff) ? T_SIG0 : T_DRD;
        end
        T_SIG0: begin
          if (f_r > sgns_pkg::LIMIT_Q24) begin
            sig_sel_r <= 2'd1;
          end else if (f_r < -sgns_pkg::LIMIT_Q24) begin
            sig_sel_r <= 2'd2;
          end else begin
            sig_sel_r <= 2'd0;
          end
          state_r <= T_SIG1;
        end
        T_SIG1: state_r <= T_GRAD;
        T_GRAD: begin
          g_r   <= prod_fl[26:0];
          cnt_r <= '0;
          state_r <= (dim_eff == 8'd0) ? T_NEXT : T_URD;
        end
        T_URD: state_r <= T_UM1;
        T_UM1: state_r <= T_UM2;
        T_UM2: state_r <= T_UW;
        T_UW: begin
          cnt_r <= cnt_inc;
          state_r <= (cnt_inc == dim_eff) ? T_NEXT : T_URD;
        end
        T_NEXT: begin
          first_r <= 1'b0;
          cnt_r   <= '0;
          if (drawn_r == neg_cfg_r) begin
            state_r <= (dim_eff == 8'd0) ? S_FIN : T_FRD;
          end else begin
            ma_r    <= {2'd0, rand_r};
            mb_r    <= sgns_pkg::LCG_MUL;
            mp_r    <= '0;
            mcnt_r  <= 6'd35;
            state_r <= T_LCG;
          end
        end
        T_LCG: begin
          mp_r   <= mp_step;
          ma_r   <= {ma_r[64:0], 1'b0};
          mb_r   <= {1'b0, mb_r[34:1]};
          mcnt_r <= mcnt_r - 6'd1;
          if (mcnt_r == 6'd1) begin
            state_r <= T_LSTORE;
          end
        end
        T_LSTORE: begin
          rand_r  <= mp_r[63:0] + sgns_pkg::LCG_ADD;
          state_r <= T_UNI;
        end
        T_UNI: begin
          drawn_r <= drawn_r + 4'd1;
          state_r <= T_UCHK;
        end
        T_UCHK: begin
          if (uni_q_r == 12'd0) begin
            dn_r    <= rand_r;
            dd_r    <= {22'd0, veff_m1};
            dr_r    <= '0;
            dq_r    <= '0;
            dcnt_r  <= 7'd64;
            state_r <= T_MOD;
          end else if (uni_q_r == node_r) begin
            state_r <= T_NEXT;
          end else begin
            tgt_r     <= uni_q_r;
            lab_one_r <= 1'b0;
            f_r       <= '0;
            cnt_r     <= '0;
            state_r   <= (dim_eff == 8'd0) ? T_SIG0 : T_DRD;
          end
        end
        T_MOD: begin
          dr_r   <= dr_step;
          dq_r   <= {dq_r[23:0], div_ge};
          dn_r   <= {dn_r[62:0], 1'b0};
          dcnt_r <= dcnt_r - 7'd1;
          if (dcnt_r == 7'd1) begin
            state_r <= T_MODDONE;
          end
        end
        T_MODDONE: begin
          if (mod_cand == node_r) begin
            state_r <= T_NEXT;
          end else begin
            tgt_r     <= mod_cand;
            lab_one_r <= 1'b0;
            f_r       <= '0;
            cnt_r     <= '0;
            state_r   <= (dim_eff == 8'd0) ? T_SIG0 : T_DRD;
          end
        end
        T_FRD: state_r <= T_FW;
        T_FW: begin
          cnt_r <= cnt_inc;
          state_r <= (cnt_inc == dim_eff) ? S_FIN : T_FRD;
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          sgns_pkg::CFG_DIM:   dim_cfg_r <= cfg_data[7:0];
          sgns_pkg::CFG_NEG:   neg_cfg_r <= cfg_data[3:0];
          sgns_pkg::CFG_RATE:  rate_r    <= cfg_data[24:0];
          sgns_pkg::CFG_VOCAB: vocab_r   <= cfg_data[12:0];
          sgns_pkg::CFG_SEED:  rand_r    <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_done_kind  = out_done_kind_r;

`ifndef SYNTHESIS
  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && out_stall) |=> (state_r == S_FIN))
    else $error("finished request left before its result could be delivered");
  a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_read_value_r != 32'sd0) |-> (out_done_kind_r == sgns_pkg::CMD_READ))
    else $error("non-zero read value on a request that is not a read");
  a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == T_DRD || state_r == T_URD || state_r == T_FRD) |-> (cnt_r < dim_eff))
    else $error("element counter beyond the vector length");
`endif

endmodule
`default_nettype wire

// ===== test/sgns_checker.sv =====
// Checker for the skip-gram trainer: predicts every response and compares it with the block.
`timescale 1ns / 1ps
module sgns_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire  [2:0]        in_command,
  input  wire  [11:0]       in_node,
  input  wire  [11:0]       in_context_node,
  input  wire  [15:0]       in_position,
  input  wire signed [31:0] in_element_value,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire signed [31:0] out_read_value,
  input  wire  [2:0]        out_done_kind,
  input  wire               cfg_we,
  input  wire  [2:0]        cfg_index,
  input  wire  [63:0]       cfg_data,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [2:0]         done_kind;
  } response_t;

  localparam longint ONE = 64'sd16777216;
  localparam longint LIM = 64'sd100663296;

  response_t          responses_due[$];
  int                 in_vec [0:4096*sgns_pkg::DIM-1];
  int                 out_vec[0:4096*sgns_pkg::DIM-1];
  logic [11:0]        unigram[0:65535];
  int                 sigmoid[0:sgns_pkg::SIG_ENTRIES-1];
  int                 err_acc[0:sgns_pkg::DIM-1];
  logic [7:0]         dim_r;
  logic [3:0]         neg_r;
  logic [24:0]        rate_r;
  logic [12:0]        vocab_r;
  longint unsigned    lcg;

  function automatic int sat(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  initial begin
    longint unsigned e, den, s;
    e = 64'd1 << 32;
    for (int m = 0; m <= sgns_pkg::SIG_HALF; m++) begin
      den = (64'd1 << 32) + e;
      s = ((64'd1 << 56) + den / 2) / den;
      if (sgns_pkg::SIG_HALF + m < sgns_pkg::SIG_ENTRIES)
        sigmoid[sgns_pkg::SIG_HALF + m] = int'(s);
      if (m > 0) sigmoid[sgns_pkg::SIG_HALF - m] = int'(64'd16777216 - s);
      e = (e * 64'd4243735693 + (64'd1 << 31)) >> 32;
    end
  end

  task automatic train_pair(int center, int ctx);
    int              dim, veff, tgt, bi, bo;
    longint          f, s, g, lab;
    longint unsigned idx;
    dim = (dim_r > sgns_pkg::DIM) ? sgns_pkg::DIM : dim_r;
    veff = (vocab_r < 2) ? 2 : ((vocab_r > 4096) ? 4096 : vocab_r);
    bi = ctx * sgns_pkg::DIM;
    for (int c = 0; c < sgns_pkg::DIM; c++) err_acc[c] = 0;
    if (neg_r > 0) begin
      for (int d = 0; d <= neg_r; d++) begin
        if (d == 0) begin
          tgt = center;
          lab = ONE;
        end else begin
          lcg = lcg * 64'd25214903917 + 64'd11;
          tgt = unigram[(lcg >> 16) & 64'hffff];
          if (tgt == 0) tgt = int'(lcg % longint'(veff - 1)) + 1;
          if (tgt == center) continue;
          lab = 0;
        end
        bo = tgt * sgns_pkg::DIM;
        f = 0;
        for (int c = 0; c < dim; c++) f += (longint'(in_vec[bi + c]) * out_vec[bo + c]) >>> 24;
        if (f > LIM) s = ONE;
        else if (f < -LIM) s = 0;
        else begin
          idx = (longint'(f + LIM) * 83) >> 24;
          if (idx >= sgns_pkg::SIG_ENTRIES) idx = sgns_pkg::SIG_ENTRIES - 1;
          s = sigmoid[idx];
        end
        g = ((lab - s) * longint'(rate_r)) >>> 24;
        for (int c = 0; c < dim; c++)
          err_acc[c] = sat(longint'(err_acc[c]) + ((g * out_vec[bo + c]) >>> 24));
        for (int c = 0; c < dim; c++)
          out_vec[bo + c] = sat(longint'(out_vec[bo + c]) + ((g * in_vec[bi + c]) >>> 24));
      end
    end
    for (int c = 0; c < dim; c++) in_vec[bi + c] = sat(longint'(in_vec[bi + c]) + err_acc[c]);
  endtask

  always @(posedge clk) begin
    response_t r, want;
    if (!rst_n) begin
      dim_r <= sgns_pkg::DIM_RESET;
      neg_r <= sgns_pkg::NEG_RESET;
      rate_r <= sgns_pkg::RATE_RESET;
      vocab_r <= sgns_pkg::VOCAB_RESET;
      lcg = sgns_pkg::SEED_RESET;
      responses_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sgns_pkg::CFG_DIM:   dim_r <= cfg_data[7:0];
          sgns_pkg::CFG_NEG:   neg_r <= cfg_data[3:0];
          sgns_pkg::CFG_RATE:  rate_r <= cfg_data[24:0];
          sgns_pkg::CFG_VOCAB: vocab_r <= cfg_data[12:0];
          sgns_pkg::CFG_SEED:  lcg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        r.read_value = 0;
        r.done_kind = in_command;
        case (in_command)
          sgns_pkg::CMD_TABLE_WR: unigram[in_position] = in_node;
          sgns_pkg::CMD_IN_WR:
            if (in_position < sgns_pkg::DIM)
              in_vec[in_node * sgns_pkg::DIM + in_position] = in_element_value;
          sgns_pkg::CMD_OUT_WR:
            if (in_position < sgns_pkg::DIM)
              out_vec[in_node * sgns_pkg::DIM + in_position] = in_element_value;
          sgns_pkg::CMD_TRAIN: train_pair(in_node, in_context_node);
          sgns_pkg::CMD_READ:
            if (in_position < sgns_pkg::DIM)
              r.read_value = in_vec[in_node * sgns_pkg::DIM + in_position];
          default: ;
        endcase
        responses_due.push_back(r);
      end
      if (out_valid && !out_stall) begin
        if (responses_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected response: value %0d kind %0d",
                                         out_read_value, out_done_kind);
        end else begin
          want = responses_due.pop_front();
          if (want.read_value !== out_read_value || want.done_kind !== out_done_kind) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Mismatch: expected value %0d kind %0d, got value %0d kind %0d",
                       want.read_value, want.done_kind, out_read_value, out_done_kind);
          end
        end
      end
    end
    pending = responses_due.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the skip-gram trainer: reset, configuration, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  wire                in_stall;
  logic [2:0]         in_command = 0;
  logic [11:0]        in_node = 0;
  logic [11:0]        in_context_node = 0;
  logic [15:0]        in_position = 0;
  logic signed [31:0] in_element_value = 0;
  wire                out_valid;
  logic               out_stall = 0;
  wire signed [31:0]  out_read_value;
  wire [2:0]          out_done_kind;
  logic               cfg_we = 0;
  logic [2:0]         cfg_index = 0;
  logic [63:0]        cfg_data = 0;
  int                 fail_count, pending;
  logic               idling = 0;
  int                 cycles = 0;
  int                 far_rows[$];
  int                 far_pos[$];

  always #5 clk = ~clk;

  skipgram_negative_sampling_update_top i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_node, .in_context_node,
    .in_position, .in_element_value, .out_valid, .out_stall, .out_read_value,
    .out_done_kind, .cfg_we, .cfg_index, .cfg_data
  );

  sgns_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_command, .in_node, .in_context_node,
    .in_position, .in_element_value, .out_valid, .out_stall, .out_read_value,
    .out_done_kind, .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending
  );

  always @(posedge clk) begin
    out_stall <= idling && ($urandom_range(99) < 36);
    cycles <= cycles + 1;
    if (cycles > 6000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send(logic [2:0] cmd, int node, int ctx, int pos, logic [31:0] val);
    bit stalled;
    if (idling && $urandom_range(99) < 36) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    in_command <= cmd;
    in_node <= 12'(node);
    in_context_node <= 12'(ctx);
    in_position <= 16'(pos);
    in_element_value <= val;
    if (cmd == sgns_pkg::CMD_IN_WR && pos < sgns_pkg::DIM && node >= 16) begin
      far_rows.push_back(node);
      far_pos.push_back(pos);
    end
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic write_regs(int dim, int neg, int rate, int vocab, logic [63:0] seed);
    cfg_write(sgns_pkg::CFG_DIM, 64'(dim));
    cfg_write(sgns_pkg::CFG_NEG, 64'(neg));
    cfg_write(sgns_pkg::CFG_RATE, 64'(rate));
    cfg_write(sgns_pkg::CFG_VOCAB, 64'(vocab));
    cfg_write(sgns_pkg::CFG_SEED, seed);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] rand_value();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(32'h0200_0000) - 32'h0100_0000;
  endfunction

  task automatic random_request();
    int k, sel;
    k = $urandom_range(99);
    if (k < 35) begin
      send(sgns_pkg::CMD_TRAIN, $urandom_range(15), $urandom_range(15), $urandom, $urandom);
    end else if (k < 55) begin
      if (far_rows.size() > 0 && $urandom_range(2) == 0) begin
        sel = $urandom_range(far_rows.size() - 1);
        send(sgns_pkg::CMD_READ, far_rows[sel], $urandom, far_pos[sel], $urandom);
      end else if ($urandom_range(4) == 0) begin
        send(sgns_pkg::CMD_READ, $urandom, $urandom, $urandom_range(sgns_pkg::DIM, 65535),
             $urandom);
      end else begin
        send(sgns_pkg::CMD_READ, $urandom_range(15), $urandom,
             $urandom_range(sgns_pkg::DIM - 1), $urandom);
      end
    end else if (k < 70) begin
      if ($urandom_range(1)) send(sgns_pkg::CMD_IN_WR, $urandom, $urandom, $urandom, rand_value());
      else send(sgns_pkg::CMD_IN_WR, $urandom_range(15), $urandom,
                $urandom_range(sgns_pkg::DIM - 1), rand_value());
    end else if (k < 80) begin
      send(sgns_pkg::CMD_OUT_WR, $urandom_range(1) ? $urandom : $urandom_range(15), $urandom,
           $urandom_range(1) ? $urandom : $urandom_range(sgns_pkg::DIM - 1), rand_value());
    end else if (k < 92) begin
      send(sgns_pkg::CMD_TABLE_WR, $urandom_range(15), $urandom, $urandom, $urandom);
    end else begin
      send($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic random_phase(int dim, int neg, int rate, int vocab, int count);
    drain();
    write_regs(dim, neg, rate, vocab, {$urandom, $urandom});
    for (int i = 0; i < count; i++) random_request();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    write_regs(8, 5, 419430, 16, {$urandom, $urandom});
    for (int p = 0; p < 65536; p++) send(sgns_pkg::CMD_TABLE_WR, $urandom_range(15), 0, p, 0);
    for (int r = 0; r < 16; r++) begin
      for (int e = 0; e < sgns_pkg::DIM; e++) begin
        send(sgns_pkg::CMD_IN_WR, r, 0, e, rand_value());
        send(sgns_pkg::CMD_OUT_WR, r, 0, e, rand_value());
      end
    end
    idling = 1;
    send(sgns_pkg::CMD_IN_WR, 4095, 4095, sgns_pkg::DIM - 1, 32'h8000_0000);
    send(sgns_pkg::CMD_READ, 4095, 0, sgns_pkg::DIM - 1, 0);
    send(sgns_pkg::CMD_IN_WR, 4095, 0, 65535, 32'h7fff_ffff);
    send(sgns_pkg::CMD_READ, 4095, 0, 65535, 32'hffff_ffff);
    send(sgns_pkg::CMD_OUT_WR, 4095, 0, sgns_pkg::DIM - 1, 32'h7fff_ffff);
    send(sgns_pkg::CMD_OUT_WR, 0, 0, 65535, 32'h8000_0000);
    send(sgns_pkg::CMD_IN_WR, 0, 0, 0, 32'h7fff_ffff);
    send(sgns_pkg::CMD_IN_WR, 1, 0, 0, 32'h8000_0000);
    send(sgns_pkg::CMD_TABLE_WR, 4095, 0, 65535, 0);
    send(sgns_pkg::CMD_TABLE_WR, 0, 0, 65535, 0);
    send(sgns_pkg::CMD_TABLE_WR, 15, 0, 0, 0);
    send(sgns_pkg::CMD_TRAIN, 3, 3, 0, 0);
    send(sgns_pkg::CMD_TRAIN, 0, 1, 0, 0);
    send(sgns_pkg::CMD_TRAIN, 15, 0, 0, 0);
    send(sgns_pkg::CMD_READ, 1, 0, 0, 0);
    send(sgns_pkg::CMD_READ, 0, 0, 0, 0);
    send(3'd5, 4095, 4095, 65535, 32'hffff_ffff);
    send(3'd6, 0, 0, 0, 0);
    send(3'd7, 1, 2, 3, 4);
    random_phase(8, 5, 419430, 16, 40);
    random_phase(0, 4, 1000000, 16, 20);
    random_phase(1, 15, 16777216, 2, 40);
    random_phase(255, 2, 0, 16, 15);
    random_phase(16, 1, 33554431, 9, 40);
    random_phase(255, 0, 8388608, 8191, 20);
    random_phase(4, 7, $urandom_range(16777216), 16, 50);
    random_phase(128, 15, 2000000, 16, 15);
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
